// ===== hdl/md5d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 digest package
// Round constants, rotate amounts, message word schedule and the command
// struct that the sequencer sends to the message block buffer.
// ----------------------------------------------------------------------------
package md5d_pkg;

    // Round groups, selected by bits 5:4 of the round index.
    localparam logic [1:0] GRP_F = 2'd0;
    localparam logic [1:0] GRP_G = 2'd1;
    localparam logic [1:0] GRP_H = 2'd2;
    localparam logic [1:0] GRP_I = 2'd3;

    // Initial chaining values A..D.
    localparam logic [31:0] CHAIN_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // Additive round constants.
    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {group, round[1:0]}.
    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message byte position at which the length no longer fits the block.
    localparam logic [5:0] LEN_LIMIT_POS = 6'd56;

    // Commands from the sequencer to the block buffer.
    typedef struct packed {
        logic        byte_we;   // store one message byte
        logic        pad_we;    // append 0x80 and zero fill
        logic        len_only;  // when padding, also write the length words
        logic        len_we;    // clear the block and write the length words
        logic [5:0]  pos;       // byte position within the block
        logic [7:0]  data;      // message byte
        logic [63:0] bit_len;   // message length in bits
    } msg_cmd_t;

    // Message word used by a round.
    function automatic logic [3:0] word_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        begin
            r4 = rnd[3:0];
            case (rnd[5:4])
                GRP_F: idx = r4;
                GRP_G: idx = 4'((r4 << 2) + r4 + 4'd1);
                GRP_H: idx = 4'((r4 << 1) + r4 + 4'd5);
                GRP_I: idx = 4'((r4 << 3) - r4);
                default: idx = r4;
            endcase
            return idx;
        end
    endfunction

    // Left rotate of a 32-bit word.
    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] amt);
        logic [63:0] dbl;
        begin
            dbl = {x, x} << amt;
            return dbl[63:32];
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/md5d_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 round unit
// One compression round: the nonlinear function, the four-term add, the
// rotate and the final add. Shared by all 64 rounds of a block.
// ----------------------------------------------------------------------------
module md5d_round (
    input  wire logic [5:0]  round_idx,
    input  wire logic [31:0] a_in,
    input  wire logic [31:0] b_in,
    input  wire logic [31:0] c_in,
    input  wire logic [31:0] d_in,
    input  wire logic [31:0] msg_word,
    output logic [31:0]      a_out,
    output logic [31:0]      b_out,
    output logic [31:0]      c_out,
    output logic [31:0]      d_out
);

    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [4:0]  rot_amt;

    // Nonlinear function of the current group.
    always_comb begin
        case (round_idx[5:4])
            md5d_pkg::GRP_F: f_val = (b_in & c_in) | (~b_in & d_in);
            md5d_pkg::GRP_G: f_val = (d_in & b_in) | (~d_in & c_in);
            md5d_pkg::GRP_H: f_val = b_in ^ c_in ^ d_in;
            md5d_pkg::GRP_I: f_val = c_in ^ (b_in | ~d_in);
            default:         f_val = b_in ^ c_in ^ d_in;
        endcase
    end

    // Sum, rotate and register shuffle.
    always_comb begin
        rot_amt = md5d_pkg::ROT_TABLE[{round_idx[5:4], round_idx[1:0]}];
        sum_val = f_val + a_in + md5d_pkg::K_TABLE[round_idx] + msg_word;
        a_out   = d_in;
        d_out   = c_in;
        c_out   = b_in;
        b_out   = b_in + md5d_pkg::rotl32(sum_val, rot_amt);
    end

endmodule
`default_nettype wire

// ===== hdl/md5d_msg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 message block buffer
// Sixteen 32-bit words filled little-endian one byte at a time, with the
// padding and length writes, and one read port for the round unit.
// ----------------------------------------------------------------------------
module md5d_msg (
    input  wire logic               aclk,
    input  wire md5d_pkg::msg_cmd_t cmd,
    input  wire logic [3:0]         rd_idx,
    output logic [31:0]             rd_word
);

    logic [31:0] word_reg  [16];
    logic [31:0] word_next [16];
    logic [3:0]  widx;
    logic [4:0]  lane_base;

    assign widx      = cmd.pos[5:2];
    assign lane_base = {cmd.pos[1:0], 3'b000};

    // Next value of every word.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            word_next[i] = word_reg[i];
            if (cmd.byte_we && (4'(i) == widx)) begin
                if (cmd.pos[1:0] == 2'd0) begin
                    word_next[i] = 32'(cmd.data);
                end else begin
                    word_next[i][lane_base +: 8] = cmd.data;
                end
            end
            if (cmd.pad_we) begin
                if (4'(i) == widx) begin
                    if (cmd.pos[1:0] == 2'd0) begin
                        word_next[i] = 32'h0000_0080;
                    end else begin
                        word_next[i][lane_base +: 8] = 8'h80;
                    end
                end else if (4'(i) > widx) begin
                    word_next[i] = '0;
                end
                if (cmd.len_only && (i == 14)) begin
                    word_next[i] = cmd.bit_len[31:0];
                end
                if (cmd.len_only && (i == 15)) begin
                    word_next[i] = cmd.bit_len[63:32];
                end
            end
            if (cmd.len_we) begin
                if (i == 14) begin
                    word_next[i] = cmd.bit_len[31:0];
                end else if (i == 15) begin
                    word_next[i] = cmd.bit_len[63:32];
                end else begin
                    word_next[i] = '0;
                end
            end
        end
    end

    // Word storage, no reset: every word is written before it is read.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            word_reg[i] <= word_next[i];
        end
    end

    assign rd_word = word_reg[rd_idx];

endmodule
`default_nettype wire

// ===== hdl/md5_digest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 digest
// Byte-stream MD5 engine with a shared round unit under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_valid/s_ready) carries one item per byte: s_kind 0
//   with s_data_byte, or s_kind 1 to close the message. The result channel
//   (m_valid/m_ready) returns the 16 digest bytes, least significant byte of
//   word A first, with m_digest_last set on the sixteenth.
//   A byte item is written into the block buffer, except the byte that
//   completes a 64-byte block, which also runs the compression: 64 rounds
//   through the single round unit, then one chaining add, before s_ready rises.
//   An end item pads the block and compresses it; if fewer than eight
//   bytes of room remain, a second length-only block is written and compressed.
//   The 16 digest bytes then go out at one per cycle while m_ready is high.
//   The round unit's 64 rounds per block set the rate.
//   While the digest waits on m_ready, s_ready stays low and the bytes hold.
//   After the last byte is taken the chaining values and length return to
//   their initial values. Reset (aresetn low, synchronous) does the same and
//   drops both valid and pending work.
// ----------------------------------------------------------------------------
module md5_digest (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_data_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_digest_byte,
    output logic            m_digest_last
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg,     state_next;
    logic [5:0]  round_idx_reg, round_idx_next;
    logic [3:0]  out_idx_reg,   out_idx_next;
    logic        pend_len_reg,  pend_len_next;
    logic        emit_reg,      emit_next;
    logic [63:0] bit_cnt_reg,   bit_cnt_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] work_reg [4];
    logic [31:0] work_next [4];

    logic               in_fire;
    logic               out_fire;
    logic [5:0]         pos;
    md5d_pkg::msg_cmd_t msg_cmd;
    logic [31:0]        msg_word;
    logic [31:0]        rnd_a, rnd_b, rnd_c, rnd_d;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign pos      = bit_cnt_reg[8:3];

    // Block buffer commands.
    always_comb begin
        msg_cmd          = '0;
        msg_cmd.pos      = pos;
        msg_cmd.data     = s_data_byte;
        msg_cmd.bit_len  = bit_cnt_reg;
        msg_cmd.byte_we  = in_fire && !s_kind;
        msg_cmd.pad_we   = in_fire && s_kind;
        msg_cmd.len_only = (pos < md5d_pkg::LEN_LIMIT_POS);
        msg_cmd.len_we   = (state_reg == ST_LEN);
    end

    md5d_msg u_msg (
        .aclk    (aclk),
        .cmd     (msg_cmd),
        .rd_idx  (md5d_pkg::word_index(round_idx_reg)),
        .rd_word (msg_word)
    );

    md5d_round u_round (
        .round_idx (round_idx_reg),
        .a_in      (work_reg[0]),
        .b_in      (work_reg[1]),
        .c_in      (work_reg[2]),
        .d_in      (work_reg[3]),
        .msg_word  (msg_word),
        .a_out     (rnd_a),
        .b_out     (rnd_b),
        .c_out     (rnd_c),
        .d_out     (rnd_d)
    );

    // Sequencer and datapath next values.
    always_comb begin
        state_next     = state_reg;
        round_idx_next = round_idx_reg;
        out_idx_next   = out_idx_reg;
        pend_len_next  = pend_len_reg;
        emit_next      = emit_reg;
        bit_cnt_next   = bit_cnt_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;

        case (state_reg)
            ST_IDLE: begin
                work_next = chain_reg;
                if (in_fire) begin
                    if (!s_kind) begin
                        bit_cnt_next = bit_cnt_reg + 64'd8;
                        if (pos == 6'd63) begin
                            state_next = ST_ROUND;
                        end
                    end else begin
                        emit_next     = 1'b1;
                        pend_len_next = (pos >= md5d_pkg::LEN_LIMIT_POS);
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                work_next      = '{rnd_a, rnd_b, rnd_c, rnd_d};
                round_idx_next = round_idx_reg + 6'd1;
                if (round_idx_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (pend_len_reg) begin
                    state_next = ST_LEN;
                end else if (emit_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEN: begin
                // The buffer is rewritten with the length block this cycle.
                work_next     = chain_reg;
                pend_len_next = 1'b0;
                state_next    = ST_ROUND;
            end
            ST_OUT: begin
                if (out_fire) begin
                    out_idx_next = out_idx_reg + 4'd1;
                    if (out_idx_reg == 4'd15) begin
                        chain_next   = md5d_pkg::CHAIN_INIT;
                        bit_cnt_next = '0;
                        emit_next    = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and chaining registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            round_idx_reg <= '0;
            out_idx_reg   <= '0;
            pend_len_reg  <= 1'b0;
            emit_reg      <= 1'b0;
            bit_cnt_reg   <= '0;
            chain_reg     <= md5d_pkg::CHAIN_INIT;
        end else begin
            state_reg     <= state_next;
            round_idx_reg <= round_idx_next;
            out_idx_reg   <= out_idx_next;
            pend_len_reg  <= pend_len_next;
            emit_reg      <= emit_next;
            bit_cnt_reg   <= bit_cnt_next;
            chain_reg     <= chain_next;
        end
    end

    // Working variables A..D.
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    // Digest byte straight from the chaining words.
    assign m_digest_byte = chain_reg[out_idx_reg[3:2]][{out_idx_reg[1:0], 3'b000} +: 8];
    assign m_digest_last = (out_idx_reg == 4'd15);

    // The block never takes an item while a digest is waiting.
    assert property (@(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid)
        else $error("input taken while digest pending");

    // The round counter rests at zero outside the compression.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROUND) |-> (round_idx_reg == 6'd0))
        else $error("round counter not idle outside compression");

    // A second length block is only scheduled when a digest will follow.
    assert property (@(posedge aclk) disable iff (!aresetn) pend_len_reg |-> emit_reg)
        else $error("length block without end of message");

    // After the last digest byte the engine is back at its initial state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_digest_last) |=>
        (chain_reg[0] == md5d_pkg::CHAIN_INIT[0]) && (bit_cnt_reg == 64'd0) && s_ready)
        else $error("state not restored after digest");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// MD5 digest testbench
// Streams byte messages of many lengths into md5_digest, including the
// padding boundaries that need a second block. A software MD5 inside a small
// scoreboard predicts the 16 digest bytes of every message. Both handshakes
// idle at random: the sender in bursts with gaps, the receiver in stall modes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit KIND_BYTE = 1'b0;
    localparam bit KIND_END  = 1'b1;

    // Per-round additive constants.
    localparam bit [31:0] ADD_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, four per round group.
    localparam int SHIFT_BY [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    localparam bit [31:0] IV_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam int RANDOM_ITEMS = 430;

    typedef struct {
        bit [7:0] digest_byte;
        bit       digest_last;
    } digest_out_t;

    // Software MD5 of the byte stream plus the queue of digest bytes it owes.
    class md5_scoreboard;
        bit [31:0]   chain [4];
        bit [31:0]   msg_words [16];
        bit [63:0]   bit_count;
        digest_out_t owed [$];
        int          errors;

        function new();
            chain     = IV_WORDS;
            bit_count = 0;
            errors    = 0;
            foreach (msg_words[i]) msg_words[i] = 0;
        endfunction

        // One 64-round compression of msg_words into chain.
        function void compress();
            bit [31:0] a, b, c, d, f, sum;
            int        w;
            int        sh;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++) begin
                case (r / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        w = r;
                    end
                    1: begin
                        f = (d & b) | (~d & c);
                        w = (5 * r + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        w = (3 * r + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        w = (7 * r) % 16;
                    end
                endcase
                sh  = SHIFT_BY[(r / 16) * 4 + (r % 4)];
                sum = f + a + ADD_CONST[r] + msg_words[w];
                a   = d;
                d   = c;
                c   = b;
                b   = b + ((sum << sh) | (sum >> (32 - sh)));
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        // Absorbs an accepted input item; an end marker queues the digest.
        function void note_item(bit kind, bit [7:0] data);
            bit [5:0]    pos;
            int          sh;
            bit [7:0]    value;
            digest_out_t out;
            pos   = bit_count[8:3];
            sh    = pos[1:0] * 8;
            value = (kind == KIND_BYTE) ? data : 8'h80;
            if (pos[1:0] == 2'd0) begin
                msg_words[pos[5:2]] = {24'h0, value};
            end else begin
                msg_words[pos[5:2]] |= {24'h0, value} << sh;
            end
            if (kind == KIND_BYTE) begin
                bit_count += 64'd8;
                if (pos == 6'd63) begin
                    compress();
                end
                return;
            end
            // Padding, then the length, in a second block when it does not fit.
            for (int i = pos[5:2] + 1; i < 16; i++) msg_words[i] = 0;
            if (pos >= 6'd56) begin
                compress();
                foreach (msg_words[i]) msg_words[i] = 0;
            end
            msg_words[14] = bit_count[31:0];
            msg_words[15] = bit_count[63:32];
            compress();
            for (int k = 0; k < 16; k++) begin
                out.digest_byte = 8'(chain[k / 4] >> ((k % 4) * 8));
                out.digest_last = (k == 15);
                owed.push_back(out);
            end
            chain     = IV_WORDS;
            bit_count = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // Compares one accepted digest byte with the oldest one owed.
        task check_result(bit [7:0] got_byte, bit got_last);
            digest_out_t want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected digest byte %02h last %0d", got_byte, got_last));
                return;
            end
            want = owed.pop_front();
            if (got_byte !== want.digest_byte) begin
                report($sformatf("digest byte %02h, expected %02h", got_byte,
                                 want.digest_byte));
            end
            if (got_last !== want.digest_last) begin
                report($sformatf("digest last %0d, expected %0d", got_last,
                                 want.digest_last));
            end
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_kind;
    logic [7:0] s_data_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_digest_byte;
    logic       m_digest_last;

    md5_scoreboard sb = new();
    int            burst_left = 0;
    int            items_sent = 0;

    md5_digest DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_byte (m_digest_byte),
        .m_digest_last (m_digest_last)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sends one item, opening a new burst after a random gap when due.
    task automatic send_item(input bit kind, input bit [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_data_byte <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(kind, data);
        burst_left--;
        items_sent++;
    endtask

    // Sends a message of len bytes and its end marker. Fill mode 0 gives
    // random bytes, 1 all zeros, 2 all ones.
    task automatic send_message(input int len, input int fill);
        bit [7:0] value;
        for (int i = 0; i < len; i++) begin
            case (fill)
                1:       value = 8'h00;
                2:       value = 8'hff;
                default: value = 8'($urandom);
            endcase
            send_item(KIND_BYTE, value);
        end
        send_item(KIND_END, 8'($urandom));
    endtask

    // Stimulus and end of run.
    initial begin
        int pick;
        int len;
        s_valid     = 1'b0;
        s_kind      = 1'b0;
        s_data_byte = 8'h00;
        aresetn     = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty message, byte extremes, a marker carrying data.
        send_item(KIND_END, 8'h00);
        send_item(KIND_END, 8'hff);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_END, 8'h00);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_END, 8'h5a);
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_END, 8'hff);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'h7f);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'hfe);
        send_item(KIND_BYTE, 8'h55);
        send_item(KIND_BYTE, 8'haa);
        send_item(KIND_END, 8'h80);

        // Random messages, weighted toward the padding boundaries.
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                len = $urandom_range(0, 8);
            end else if (pick < 6) begin
                case ($urandom_range(0, 8))
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 57;
                    3:       len = 63;
                    4:       len = 64;
                    5:       len = 65;
                    6:       len = 119;
                    7:       len = 120;
                    default: len = 128;
                endcase
            end else begin
                len = $urandom_range(0, 100);
            end
            send_message(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain the digest bytes, then watch for stray output.
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Receiver stalls: runs of always ready, coin flips, periodic gaps and
    // mostly stalled.
    initial begin
        int mode;
        int run;
        int period;
        m_ready = 1'b0;
        forever begin
            mode   = $urandom_range(0, 3);
            run    = $urandom_range(20, 200);
            period = $urandom_range(2, 9);
            for (int i = 0; i < run; i++) begin
                @(negedge aclk);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ((i % period) != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Result checking at every accepted digest byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_digest_byte, m_digest_last);
        end
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

endmodule
